FILE: rtl/core/ppu_pkg.sv
package ppu_pkg;

    localparam logic CMD_EMIT = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] init_pos_x;
        logic signed [31:0] init_pos_y;
        logic signed [31:0] init_pos_z;
        logic signed [31:0] init_vel_x;
        logic signed [31:0] init_vel_y;
        logic signed [31:0] init_vel_z;
        logic        [31:0] init_size;
        logic        [31:0] init_color;
        logic signed [31:0] init_life;
        logic        [23:0] step_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] cur_pos_x;
        logic signed [31:0] cur_pos_y;
        logic signed [31:0] cur_pos_z;
        logic        [31:0] cur_size;
        logic        [31:0] cur_color;
        logic        [30:0] remaining_life;
        logic               present;
        logic               last_of_run;
    } t_out;

    // one slot of the particle memory
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [31:0] size;
        logic        [31:0] color;
        logic signed [31:0] life;
    } t_slot;

    // pos + delta, clipped to the signed 32 bit range
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                   input logic signed [40:0] delta);
        logic signed [41:0] s;
        s = {{10{pos[31]}}, pos} + {delta[40], delta};
        if (s[41] == 1'b0 && s[40:31] != 10'd0) begin
            sat_add = 32'sh7FFF_FFFF;
        end else if (s[41] == 1'b1 && s[40:31] != 10'h3FF) begin
            sat_add = 32'sh8000_0000;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

FILE: rtl/core/particle_pool_update.sv
// Particle pool: SLOTS particle slots held in one synchronous memory.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries commands.
// An emit writes the particle into the lowest free slot (life at most zero);
// with no free slot the particle is dropped and nothing is reported. An emit
// gives no output transaction.
// A tick walks the slots in order. A free slot only passes the memory read;
// a live slot passes memory read, multiply, round, add and clip, and write
// back in turn, over the single memory port as a per-slot read-modify-write
// sequence. Every surviving particle is reported in slot order on the output
// channel (o_out_valid / i_out_stall / o_out_data), the final one with
// last_of_run set; when none survives a single transaction with present
// clear and last_of_run set is sent.
// The input is stalled for the whole tick. Output stall holds the output
// register and, once a further result is ready, the slot walk as well.
// Reset (synchronous, i_rst_n low) marks every slot free and empties the
// output register; the memory contents are not cleared.
module particle_pool_update #(
    parameter int SLOTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ppu_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ppu_pkg::t_out  o_out_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    ppu_pkg::t_slot r_mem [SLOTS];
    ppu_pkg::t_slot r_rd;

    logic [2:0]         r_state;
    logic [IW-1:0]      r_idx;
    logic [SLOTS-1:0]   r_live;
    logic [23:0]        r_dt;

    logic signed [56:0] r_prod_x, r_prod_y, r_prod_z;
    logic signed [40:0] r_dlt_x, r_dlt_y, r_dlt_z;
    logic signed [31:0] r_new_x, r_new_y, r_new_z;
    logic signed [32:0] r_new_life;

    ppu_pkg::t_out      r_hold;
    logic               r_hold_vld;
    ppu_pkg::t_out      r_out;
    logic               r_out_vld;

    logic               n_free_found;
    logic [IW-1:0]      n_free_slot;
    logic signed [56:0] n_prod_x, n_prod_y, n_prod_z;
    logic signed [56:0] n_rnd_x, n_rnd_y, n_rnd_z;
    logic               n_alive;
    logic               n_out_free;
    logic               n_out_load;
    logic               n_wb_go;
    logic               n_last_idx;
    logic               n_emit;
    ppu_pkg::t_slot     n_wr;
    ppu_pkg::t_out      n_res;
    ppu_pkg::t_out      n_fin;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign n_out_free = !r_out_vld || !i_out_stall;
    assign n_last_idx = (r_idx == IW'(SLOTS - 1));
    assign n_emit     = (r_state == S_IDLE) && i_in_valid
                        && (i_in_data.command == ppu_pkg::CMD_EMIT);

    // lowest free slot
    always_comb begin
        n_free_found = 1'b0;
        n_free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                n_free_found = 1'b1;
                n_free_slot  = IW'(i);
            end
        end
    end

    assign n_prod_x = $signed(r_rd.vel_x) * $signed({1'b0, r_dt});
    assign n_prod_y = $signed(r_rd.vel_y) * $signed({1'b0, r_dt});
    assign n_prod_z = $signed(r_rd.vel_z) * $signed({1'b0, r_dt});

    // round half up, then floor by the arithmetic shift of the upper bits
    assign n_rnd_x = r_prod_x + 57'sd32768;
    assign n_rnd_y = r_prod_y + 57'sd32768;
    assign n_rnd_z = r_prod_z + 57'sd32768;

    assign n_alive = !r_new_life[32] && (r_new_life != 33'sd0);
    assign n_wb_go = !n_alive || !r_hold_vld || n_out_free;

    assign n_out_load = ((r_state == S_WB) && n_wb_go && n_alive && r_hold_vld)
                        || ((r_state == S_FIN) && n_out_free);

    always_comb begin
        n_wr       = r_rd;
        n_wr.pos_x = r_new_x;
        n_wr.pos_y = r_new_y;
        n_wr.pos_z = r_new_z;
        n_wr.life  = r_new_life[31:0];

        n_res                = '0;
        n_res.cur_pos_x      = r_new_x;
        n_res.cur_pos_y      = r_new_y;
        n_res.cur_pos_z      = r_new_z;
        n_res.cur_size       = r_rd.size;
        n_res.cur_color      = r_rd.color;
        n_res.remaining_life = r_new_life[30:0];
        n_res.present        = 1'b1;
        n_res.last_of_run    = 1'b0;

        if (r_hold_vld) begin
            n_fin = r_hold;
        end else begin
            n_fin = '0;
        end
        n_fin.last_of_run = 1'b1;
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (n_emit && n_free_found) begin
            r_mem[n_free_slot] <= '{pos_x: i_in_data.init_pos_x,
                                    pos_y: i_in_data.init_pos_y,
                                    pos_z: i_in_data.init_pos_z,
                                    vel_x: i_in_data.init_vel_x,
                                    vel_y: i_in_data.init_vel_y,
                                    vel_z: i_in_data.init_vel_z,
                                    size:  i_in_data.init_size,
                                    color: i_in_data.init_color,
                                    life:  i_in_data.init_life};
        end else if (r_state == S_WB && n_wb_go) begin
            r_mem[r_idx] <= n_wr;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
        end
        if (r_state == S_RND) begin
            r_dlt_x <= n_rnd_x[56:16];
            r_dlt_y <= n_rnd_y[56:16];
            r_dlt_z <= n_rnd_z[56:16];
        end
        if (r_state == S_ADD) begin
            r_new_x    <= ppu_pkg::sat_add(r_rd.pos_x, r_dlt_x);
            r_new_y    <= ppu_pkg::sat_add(r_rd.pos_y, r_dlt_y);
            r_new_z    <= ppu_pkg::sat_add(r_rd.pos_z, r_dlt_z);
            // live slot has life above zero, so this cannot underflow 32 bits
            r_new_life <= {r_rd.life[31], r_rd.life} - $signed({9'd0, r_dt});
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_dt <= i_in_data.step_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_live     <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.command == ppu_pkg::CMD_EMIT) begin
                            if (n_free_found) begin
                                r_live[n_free_slot] <= !i_in_data.init_life[31]
                                    && (i_in_data.init_life != 32'sd0);
                            end
                        end else begin
                            r_idx      <= '0;
                            r_hold_vld <= 1'b0;
                            r_state    <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_live[r_idx]) begin
                        r_state <= S_MUL;
                    end else if (n_last_idx) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MUL: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    // hold here while an earlier result cannot yet be passed on
                    if (n_wb_go) begin
                        r_live[r_idx] <= n_alive;
                        if (n_alive) begin
                            if (r_hold_vld) begin
                                r_out <= r_hold;
                            end
                            r_hold     <= n_res;
                            r_hold_vld <= 1'b1;
                        end
                        if (n_last_idx) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_out      <= n_fin;
                        r_hold_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
